>>> hdl/caxf_pkg.sv
// Shared constants, types and helpers for the correlation-adaptive crossfader.
package caxf_pkg;

  typedef logic signed [15:0] sample_t;

  localparam int unsigned WIN_DEPTH = 256;
  localparam int unsigned WIN_AW    = $clog2(WIN_DEPTH);

  localparam logic [12:0] ONE_Q12   = 13'd4096;
  localparam logic [14:0] ONE_Q14   = 15'd16384;
  localparam logic [47:0] FADE_DEN  = 48'd32767;
  localparam logic signed [17:0] HALF_SCALE = 18'sd16384;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_FADER = 2'd1;
  localparam logic [1:0] CFG_POLAR = 2'd2;

  localparam logic [1:0] MODE_LINEAR = 2'd0;

  // Operations of the shared multiplier.
  localparam logic [4:0] OP_OLD_AB  = 5'd0;
  localparam logic [4:0] OP_OLD_AA  = 5'd1;
  localparam logic [4:0] OP_OLD_BB  = 5'd2;
  localparam logic [4:0] OP_NEW_AB  = 5'd3;
  localparam logic [4:0] OP_NEW_AA  = 5'd4;
  localparam logic [4:0] OP_NEW_BB  = 5'd5;
  localparam logic [4:0] OP_N_SAA   = 5'd6;
  localparam logic [4:0] OP_SA_SA   = 5'd7;
  localparam logic [4:0] OP_N_SBB   = 5'd8;
  localparam logic [4:0] OP_SB_SB   = 5'd9;
  localparam logic [4:0] OP_N_SAB   = 5'd10;
  localparam logic [4:0] OP_SA_SB   = 5'd11;
  localparam logic [4:0] OP_DEN     = 5'd12;
  localparam logic [4:0] OP_MIX_AL  = 5'd13;
  localparam logic [4:0] OP_MIX_BL  = 5'd14;
  localparam logic [4:0] OP_MIX_AR  = 5'd15;
  localparam logic [4:0] OP_MIX_BR  = 5'd16;

  // Floor division by 4096 followed by saturation to a 16-bit sample.
  function automatic sample_t sat16(input logic signed [47:0] x);
    logic signed [47:0] q;
    q = x >>> 12;
    if (q > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (q < -48'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

endpackage

>>> hdl/correlation_adaptive_crossfader.sv
// Correlation-adaptive stereo crossfader with bit-serial arithmetic units.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | input     | in_valid/in_stall  | a/b left/right samples, CV, CV connected
//  out     | output    | out_valid/out_stall| mixes, law lamps, polarity lamps, correlation
//  cfg     | input     | cfg_we             | mode, fader position, polar offset
//
// One item at a time. The arithmetic runs on the shared multiplier, which
// retires one multiplier bit per cycle, and on the 62-step divider and the
// 24-step square root unit.
// Reset (rst_n low, synchronous) clears sums, fill count, write slot, latch,
// held correlation, configuration, state and out_valid; the window memory is not cleared.
// A finished result waits in the output register while the next transfer is
// accepted; the block only holds a new result back while out_stall is high.
module correlation_adaptive_crossfader
  import caxf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_a_left,
  input  logic signed [15:0]   in_b_left,
  input  logic signed [15:0]   in_a_right,
  input  logic signed [15:0]   in_b_right,
  input  logic signed [15:0]   in_cv_sample,
  input  logic                 in_cv_connected,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_mix_left,
  output logic signed [15:0]   out_mix_right,
  output logic                 out_linear_lit,
  output logic                 out_power_lit,
  output logic                 out_positive_lit,
  output logic                 out_negative_lit,
  output logic signed [15:0]   out_correlation_value,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [12:0]          cfg_data
);

  // Sequencer states.
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FADE   = 5'd1;
  localparam logic [4:0] S_FADE_W = 5'd2;
  localparam logic [4:0] S_C0     = 5'd3;
  localparam logic [4:0] S_MGO    = 5'd4;
  localparam logic [4:0] S_MW     = 5'd5;
  localparam logic [4:0] S_SQA    = 5'd6;
  localparam logic [4:0] S_SQA_W  = 5'd7;
  localparam logic [4:0] S_SQB    = 5'd8;
  localparam logic [4:0] S_SQB_W  = 5'd9;
  localparam logic [4:0] S_CHK    = 5'd10;
  localparam logic [4:0] S_CMP    = 5'd11;
  localparam logic [4:0] S_DIV_W  = 5'd12;
  localparam logic [4:0] S_LATCH  = 5'd13;
  localparam logic [4:0] S_WEIGHT = 5'd14;
  localparam logic [4:0] S_WA     = 5'd15;
  localparam logic [4:0] S_WA_W   = 5'd16;
  localparam logic [4:0] S_WB     = 5'd17;
  localparam logic [4:0] S_WB_W   = 5'd18;
  localparam logic [4:0] S_OUT    = 5'd19;

  logic [4:0] state_r;

  // Configuration registers.
  logic [1:0]  mode_r;
  logic [12:0] fader_r;
  logic        polar_r;

  // Captured input transfer.
  sample_t al_r, bl_r, ar_r, br_r, cv_r;
  logic    cvc_r;

  // Correlation state.
  logic [31:0]        win_mem [WIN_DEPTH];
  logic [31:0]        win_rd_r;
  logic [WIN_AW-1:0]  slot_r;
  logic [WIN_AW:0]    fill_r;
  logic signed [23:0] sa_r, sb_r;
  logic signed [39:0] saa_r, sbb_r, sab_r;
  logic               latched_r;
  logic signed [15:0] corr_r;
  sample_t            oa_r, ob_r;

  // Working registers of one item.
  logic [4:0]         op_r;
  logic [12:0]        fade_r, wa_r, wb_r;
  logic signed [47:0] t0_r, va_r, vb_r, cov_r, den_r, acc_r;
  logic [23:0]        sda_r, sdb_r;
  logic               lin_r, pos_r, neg_r;
  sample_t            ml_r, mr_r;

  // Output register.
  logic               out_valid_r;
  sample_t            out_ml_r, out_mr_r;
  logic               out_lin_r, out_pos_r, out_neg_r;
  logic signed [15:0] out_corr_r;

  // Fade from CV: v = cv + optional half scale; zero or below gives zero fade.
  logic signed [17:0] cv_v;
  assign cv_v = 18'(cv_r) + (polar_r ? HALF_SCALE : 18'sd0);

  // ---------------------------------------------------------------------------
  // Shared multiplier: two's-complement shift-and-add, one multiplier bit per
  // cycle. The product is kept modulo 2^48, which holds every true product here.
  // ---------------------------------------------------------------------------
  logic               mul_go;
  logic signed [47:0] mul_x;
  logic signed [24:0] mul_y;
  logic               mbusy_r;
  logic signed [47:0] mx_r, macc_r;
  logic signed [24:0] my_r;
  logic [4:0]         mcnt_r;

  assign mul_go = (state_r == S_MGO);

  always_comb begin
    mul_x = 48'sd0;
    mul_y = 25'sd0;
    unique case (op_r)
      OP_OLD_AB: begin mul_x = 48'(oa_r);  mul_y = 25'(ob_r); end
      OP_OLD_AA: begin mul_x = 48'(oa_r);  mul_y = 25'(oa_r); end
      OP_OLD_BB: begin mul_x = 48'(ob_r);  mul_y = 25'(ob_r); end
      OP_NEW_AB: begin mul_x = 48'(al_r);  mul_y = 25'(bl_r); end
      OP_NEW_AA: begin mul_x = 48'(al_r);  mul_y = 25'(al_r); end
      OP_NEW_BB: begin mul_x = 48'(bl_r);  mul_y = 25'(bl_r); end
      OP_N_SAA:  begin mul_x = 48'(saa_r); mul_y = 25'({1'b0, fill_r}); end
      OP_SA_SA:  begin mul_x = 48'(sa_r);  mul_y = 25'(sa_r); end
      OP_N_SBB:  begin mul_x = 48'(sbb_r); mul_y = 25'({1'b0, fill_r}); end
      OP_SB_SB:  begin mul_x = 48'(sb_r);  mul_y = 25'(sb_r); end
      OP_N_SAB:  begin mul_x = 48'(sab_r); mul_y = 25'({1'b0, fill_r}); end
      OP_SA_SB:  begin mul_x = 48'(sa_r);  mul_y = 25'(sb_r); end
      OP_DEN:    begin mul_x = 48'({1'b0, sda_r}); mul_y = {1'b0, sdb_r}; end
      OP_MIX_AL: begin mul_x = 48'(al_r);  mul_y = 25'({1'b0, wa_r}); end
      OP_MIX_BL: begin mul_x = 48'(bl_r);  mul_y = 25'({1'b0, wb_r}); end
      OP_MIX_AR: begin mul_x = 48'(ar_r);  mul_y = 25'({1'b0, wa_r}); end
      OP_MIX_BR: begin mul_x = 48'(br_r);  mul_y = 25'({1'b0, wb_r}); end
      default:   begin mul_x = 48'sd0;     mul_y = 25'sd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (mul_go) begin
      mbusy_r <= 1'b1;
      mx_r    <= mul_x;
      my_r    <= mul_y;
      macc_r  <= 48'sd0;
      mcnt_r  <= 5'd0;
    end else if (mbusy_r) begin
      if (my_r[0]) begin
        // The top multiplier bit carries negative weight.
        macc_r <= (mcnt_r == 5'd24) ? macc_r - mx_r : macc_r + mx_r;
      end
      mx_r   <= mx_r <<< 1;
      my_r   <= my_r >>> 1;
      mcnt_r <= mcnt_r + 5'd1;
      if (mcnt_r == 5'd24) begin
        mbusy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per cycle over a 62-bit dividend.
  // ---------------------------------------------------------------------------
  logic        div_go;
  logic [61:0] div_num;
  logic [47:0] div_den;
  logic        dbusy_r;
  logic [61:0] dnum_r;
  logic [47:0] drem_r, dden_r;
  logic [14:0] dq_r;
  logic [5:0]  dcnt_r;
  logic [47:0] d_trial;
  logic        d_ge;
  logic [47:0] cov_mag;

  assign cov_mag = cov_r[47] ? 48'(-cov_r) : 48'(cov_r);

  always_comb begin
    div_go  = 1'b0;
    div_num = 62'd0;
    div_den = FADE_DEN;
    if (state_r == S_FADE && cvc_r && cv_v > 18'sd0) begin
      div_go  = 1'b1;
      div_num = 62'({cv_v[16:0], 12'd0});
    end else if (state_r == S_CMP && cov_mag < 48'(den_r)) begin
      div_go  = 1'b1;
      div_num = {cov_mag, 14'd0};
      div_den = 48'(den_r);
    end
  end

  assign d_trial = {drem_r[46:0], dnum_r[61]};
  assign d_ge    = (d_trial >= dden_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (div_go) begin
      dbusy_r <= 1'b1;
      dnum_r  <= div_num;
      dden_r  <= div_den;
      drem_r  <= 48'd0;
      dq_r    <= 15'd0;
      dcnt_r  <= 6'd0;
    end else if (dbusy_r) begin
      drem_r <= d_ge ? d_trial - dden_r : d_trial;
      dq_r   <= {dq_r[13:0], d_ge};
      dnum_r <= dnum_r << 1;
      dcnt_r <= dcnt_r + 6'd1;
      if (dcnt_r == 6'd61) begin
        dbusy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root, two radicand bits and one root bit per cycle.
  // ---------------------------------------------------------------------------
  logic        sq_go;
  logic [47:0] sq_rad;
  logic        sbusy_r;
  logic [47:0] srad_r;
  logic [27:0] srem_r;
  logic [23:0] sroot_r;
  logic [4:0]  scnt_r;
  logic [27:0] s_cur, s_trial;
  logic [12:0] fade_inv;

  assign fade_inv = ONE_Q12 - fade_r;
  assign sq_go = (state_r == S_SQA) || (state_r == S_SQB) ||
                 (state_r == S_WA) || (state_r == S_WB);

  always_comb begin
    unique case (state_r)
      S_SQA:   sq_rad = va_r[47] ? 48'd0 : 48'(va_r);
      S_SQB:   sq_rad = vb_r[47] ? 48'd0 : 48'(vb_r);
      S_WA:    sq_rad = 48'({fade_inv, 12'd0});
      S_WB:    sq_rad = 48'({fade_r, 12'd0});
      default: sq_rad = 48'd0;
    endcase
  end

  assign s_cur   = {srem_r[25:0], srad_r[47:46]};
  assign s_trial = 28'({sroot_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sbusy_r <= 1'b0;
    end else if (sq_go) begin
      sbusy_r <= 1'b1;
      srad_r  <= sq_rad;
      srem_r  <= 28'd0;
      sroot_r <= 24'd0;
      scnt_r  <= 5'd0;
    end else if (sbusy_r) begin
      if (s_cur >= s_trial) begin
        srem_r  <= s_cur - s_trial;
        sroot_r <= {sroot_r[22:0], 1'b1};
      end else begin
        srem_r  <= s_cur;
        sroot_r <= {sroot_r[22:0], 1'b0};
      end
      srad_r <= srad_r << 2;
      scnt_r <= scnt_r + 5'd1;
      if (scnt_r == 5'd23) begin
        sbusy_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Window memory: one write per automatic item, registered read at the slot.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state_r == S_C0) begin
      win_mem[slot_r] <= {al_r, bl_r};
    end
    win_rd_r <= win_mem[slot_r];
  end

  // ---------------------------------------------------------------------------
  // Schmitt latch: set above 0.6 in magnitude, released below 0.4.
  // ---------------------------------------------------------------------------
  logic [14:0]        corr_mag;
  logic [17:0]        corr_mag5;
  logic signed [19:0] corr_x10;
  logic               latch_new;

  assign corr_mag  = corr_r[15] ? 15'(-corr_r) : corr_r[14:0];
  assign corr_mag5 = (18'(corr_mag) << 2) + 18'(corr_mag);
  assign corr_x10  = (20'(corr_r) <<< 3) + (20'(corr_r) <<< 1);

  always_comb begin
    if (latched_r) begin
      latch_new = !(corr_mag5 < 18'(2 * ONE_Q14));
    end else begin
      latch_new = (corr_mag5 > 18'(3 * ONE_Q14));
    end
  end

  logic full;
  assign full = fill_r[WIN_AW];

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= 2'd0;
      fader_r   <= 13'd0;
      polar_r   <= 1'b0;
      slot_r    <= '0;
      fill_r    <= '0;
      sa_r      <= 24'sd0;
      sb_r      <= 24'sd0;
      saa_r     <= 40'sd0;
      sbb_r     <= 40'sd0;
      sab_r     <= 40'sd0;
      latched_r <= 1'b0;
      corr_r    <= 16'sd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:  mode_r  <= cfg_data[1:0];
          CFG_FADER: fader_r <= cfg_data;
          CFG_POLAR: polar_r <= cfg_data[0];
          default:   ;
        endcase
      end

      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            al_r  <= in_a_left;
            bl_r  <= in_b_left;
            ar_r  <= in_a_right;
            br_r  <= in_b_right;
            cv_r  <= in_cv_sample;
            cvc_r <= in_cv_connected;
            state_r <= S_FADE;
          end
        end

        S_FADE: begin
          if (div_go) begin
            state_r <= S_FADE_W;
          end else begin
            if (cvc_r) begin
              fade_r <= 13'd0;
            end else begin
              fade_r <= (fader_r > ONE_Q12) ? ONE_Q12 : fader_r;
            end
            state_r <= mode_r[1] ? S_C0 : S_WEIGHT;
          end
          lin_r <= (mode_r == MODE_LINEAR);
          pos_r <= 1'b0;
          neg_r <= 1'b0;
        end

        S_FADE_W: begin
          if (!dbusy_r) begin
            fade_r  <= (dq_r > 15'(ONE_Q12)) ? ONE_Q12 : dq_r[12:0];
            state_r <= mode_r[1] ? S_C0 : S_WEIGHT;
          end
        end

        S_C0: begin
          // The registered read holds the entry about to be overwritten.
          oa_r   <= win_rd_r[31:16];
          ob_r   <= win_rd_r[15:0];
          sa_r   <= sa_r - (full ? 24'(sample_t'(win_rd_r[31:16])) : 24'sd0) + 24'(al_r);
          sb_r   <= sb_r - (full ? 24'(sample_t'(win_rd_r[15:0])) : 24'sd0) + 24'(bl_r);
          slot_r <= slot_r + 1'b1;
          if (!full) begin
            fill_r <= fill_r + 1'b1;
          end
          op_r    <= full ? OP_OLD_AB : OP_NEW_AB;
          state_r <= S_MGO;
        end

        S_MGO: begin
          state_r <= S_MW;
        end

        S_MW: begin
          if (!mbusy_r) begin
            op_r    <= op_r + 5'd1;
            state_r <= S_MGO;
            unique case (op_r)
              OP_OLD_AB: sab_r <= sab_r - macc_r[39:0];
              OP_OLD_AA: saa_r <= saa_r - macc_r[39:0];
              OP_OLD_BB: sbb_r <= sbb_r - macc_r[39:0];
              OP_NEW_AB: sab_r <= sab_r + macc_r[39:0];
              OP_NEW_AA: saa_r <= saa_r + macc_r[39:0];
              OP_NEW_BB: sbb_r <= sbb_r + macc_r[39:0];
              OP_N_SAA, OP_N_SBB, OP_N_SAB: t0_r <= macc_r;
              OP_SA_SA:  va_r <= t0_r - macc_r;
              OP_SB_SB:  vb_r <= t0_r - macc_r;
              OP_SA_SB: begin
                cov_r   <= t0_r - macc_r;
                state_r <= S_SQA;
              end
              OP_DEN: begin
                den_r   <= macc_r;
                state_r <= S_CMP;
              end
              OP_MIX_AL, OP_MIX_AR: acc_r <= macc_r;
              OP_MIX_BL: ml_r <= sat16(acc_r + macc_r + 48'sd2048);
              OP_MIX_BR: begin
                mr_r    <= sat16(acc_r + macc_r + 48'sd2048);
                state_r <= S_OUT;
              end
              default: state_r <= S_OUT;
            endcase
          end
        end

        S_SQA: state_r <= S_SQA_W;

        S_SQA_W: begin
          if (!sbusy_r) begin
            sda_r   <= sroot_r;
            state_r <= S_SQB;
          end
        end

        S_SQB: state_r <= S_SQB_W;

        S_SQB_W: begin
          if (!sbusy_r) begin
            sdb_r   <= sroot_r;
            state_r <= S_CHK;
          end
        end

        S_CHK: begin
          // A flat signal on both sides counts as full correlation, on one side as none.
          if (sda_r == 24'd0 || sdb_r == 24'd0) begin
            corr_r  <= (sda_r == sdb_r) ? 16'(ONE_Q14) : 16'sd0;
            state_r <= S_LATCH;
          end else begin
            op_r    <= OP_DEN;
            state_r <= S_MGO;
          end
        end

        S_CMP: begin
          if (div_go) begin
            state_r <= S_DIV_W;
          end else begin
            corr_r  <= cov_r[47] ? -16'(ONE_Q14) : 16'(ONE_Q14);
            state_r <= S_LATCH;
          end
        end

        S_DIV_W: begin
          if (!dbusy_r) begin
            corr_r  <= cov_r[47] ? -16'(dq_r) : 16'(dq_r);
            state_r <= S_LATCH;
          end
        end

        S_LATCH: begin
          latched_r <= latch_new;
          lin_r     <= latch_new;
          neg_r     <= (corr_x10 < -20'sd16384);
          pos_r     <= !(corr_x10 < -20'sd16384);
          state_r   <= S_WEIGHT;
        end

        S_WEIGHT: begin
          if (lin_r) begin
            wa_r    <= fade_inv;
            wb_r    <= fade_r;
            op_r    <= OP_MIX_AL;
            state_r <= S_MGO;
          end else begin
            state_r <= S_WA;
          end
        end

        S_WA: state_r <= S_WA_W;

        S_WA_W: begin
          if (!sbusy_r) begin
            wa_r    <= sroot_r[12:0];
            state_r <= S_WB;
          end
        end

        S_WB: state_r <= S_WB_W;

        S_WB_W: begin
          if (!sbusy_r) begin
            wb_r    <= sroot_r[12:0];
            op_r    <= OP_MIX_AL;
            state_r <= S_MGO;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ml_r    <= ml_r;
            out_mr_r    <= mr_r;
            out_lin_r   <= lin_r;
            out_pos_r   <= pos_r;
            out_neg_r   <= neg_r;
            out_corr_r  <= corr_r;
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall              = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_mix_left          = out_ml_r;
  assign out_mix_right         = out_mr_r;
  assign out_linear_lit        = out_lin_r;
  assign out_power_lit         = !out_lin_r;
  assign out_positive_lit      = out_pos_r;
  assign out_negative_lit      = out_neg_r;
  assign out_correlation_value = out_corr_r;

  // The arithmetic units are never busy at the same time.
  assert property (@(posedge clk) disable iff (!rst_n)
    $countones({mbusy_r, dbusy_r, sbusy_r}) <= 1)
    else $error("arithmetic units overlap");

  // The held correlation never leaves plus or minus one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (corr_r <= 16'sd16384) && (corr_r >= -16'sd16384))
    else $error("correlation out of range");

  // The fill count never passes the window depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (WIN_AW + 1)'(WIN_DEPTH))
    else $error("fill count overflow");

  // The window only advances in automatic mode.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_C0) |-> mode_r[1])
    else $error("window update outside automatic mode");

  // A result is never loaded over one that is still stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT))
    else $error("result overwritten");

endmodule

>>> tb/tb_correlation_adaptive_crossfader.sv
// Self-checking testbench for the correlation-adaptive crossfader.
`timescale 1ns / 100ps

module tb_correlation_adaptive_crossfader;
  import caxf_pkg::*;

  // Mode codes beyond the linear one that the package names.
  localparam logic [1:0] MODE_POWER    = 2'd1;
  localparam logic [1:0] MODE_AUTO     = 2'd2;
  localparam logic [1:0] MODE_AUTO_ALT = 2'd3;

  // Shapes of the left pair fed to the correlation window in automatic mode.
  localparam int SHAPE_FOLLOW   = 0;
  localparam int SHAPE_INVERT   = 1;
  localparam int SHAPE_UNRELATED = 2;
  localparam int SHAPE_A_FLAT   = 3;
  localparam int SHAPE_BOTH_FLAT = 4;

  // One predicted result transfer.
  typedef struct {
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic               linear_lit;
    logic               power_lit;
    logic               positive_lit;
    logic               negative_lit;
    logic signed [15:0] correlation;
  } mix_result_t;

  // The scoreboard carries its own copy of the registers and of the
  // correlation window, and predicts one result for every accepted sample.
  class mix_scoreboard;
    logic [1:0]  mode;
    logic [12:0] fader;
    logic        polar;
    longint      win_a[256];
    longint      win_b[256];
    longint      sum_a, sum_b, sum_aa, sum_bb, sum_ab;
    int          fill;
    int          slot;
    bit          latched;
    longint      held_corr;
    mix_result_t awaited[$];
    int          errors;

    function new();
      mode = MODE_LINEAR;
      fader = 0;
      polar = 0;
      sum_a = 0; sum_b = 0; sum_aa = 0; sum_bb = 0; sum_ab = 0;
      fill = 0;
      slot = 0;
      latched = 0;
      held_corr = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [12:0] data);
      if (idx == CFG_MODE) begin
        mode = data[1:0];
      end else if (idx == CFG_FADER) begin
        fader = data;
      end else if (idx == CFG_POLAR) begin
        polar = data[0];
      end
    endfunction

    function longint unsigned int_root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Rounded Q1.12 weighting; the arithmetic shift floors as required.
    function logic signed [15:0] weigh(longint a, longint b, longint wa, longint wb);
      longint q;
      q = (a * wa + b * wb + 2048) >>> 12;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    // Slides the window by one left pair and refreshes the correlation.
    function void slide_window(longint a, longint b);
      longint n, va, vb, cv, mag, den, q, m;
      longint unsigned sda, sdb;
      if (fill >= 256) begin
        sum_ab -= win_a[slot] * win_b[slot];
        sum_a  -= win_a[slot];
        sum_b  -= win_b[slot];
        sum_aa -= win_a[slot] * win_a[slot];
        sum_bb -= win_b[slot] * win_b[slot];
      end else begin
        fill++;
      end
      win_a[slot] = a;
      win_b[slot] = b;
      sum_ab += a * b;
      sum_a  += a;
      sum_b  += b;
      sum_aa += a * a;
      sum_bb += b * b;
      slot = (slot + 1) % 256;

      n  = fill;
      va = n * sum_aa - sum_a * sum_a;
      vb = n * sum_bb - sum_b * sum_b;
      cv = n * sum_ab - sum_a * sum_b;
      sda = int_root(va < 0 ? 0 : va);
      sdb = int_root(vb < 0 ? 0 : vb);
      if (sda == 0 || sdb == 0) begin
        held_corr = (sda == sdb) ? 16384 : 0;
      end else begin
        mag = cv < 0 ? -cv : cv;
        den = sda * sdb;
        q = (mag >= den) ? 16384 : (mag * 16384) / den;
        if (q > 16384) q = 16384;
        held_corr = cv < 0 ? -q : q;
      end
      // Hysteresis between 0.4 and 0.6 in magnitude.
      m = held_corr < 0 ? -held_corr : held_corr;
      if (latched) begin
        if (5 * m < 2 * 16384) latched = 0;
      end else begin
        if (5 * m > 3 * 16384) latched = 1;
      end
    endfunction

    function void note_sample(sample_t al, sample_t bl, sample_t ar, sample_t br,
                              sample_t cv, logic connected);
      mix_result_t r;
      longint f, v, wa, wb;
      bit lin;
      bit auto_law;
      auto_law = (mode == MODE_AUTO) || (mode == MODE_AUTO_ALT);
      if (connected) begin
        v = longint'(cv) + (polar ? 16384 : 0);
        f = (v <= 0) ? 0 : (v * 4096) / 32767;
        if (f > 4096) f = 4096;
      end else begin
        f = (fader > 4096) ? 4096 : fader;
      end
      r.positive_lit = 0;
      r.negative_lit = 0;
      if (auto_law) begin
        slide_window(al, bl);
        lin = latched;
        if (10 * held_corr < -16384) r.negative_lit = 1;
        else r.positive_lit = 1;
      end else begin
        lin = (mode == MODE_LINEAR);
      end
      if (lin) begin
        wa = 4096 - f;
        wb = f;
      end else begin
        wa = int_root((4096 - f) * 4096);
        wb = int_root(f * 4096);
      end
      r.mix_left    = weigh(al, bl, wa, wb);
      r.mix_right   = weigh(ar, br, wa, wb);
      r.linear_lit  = lin;
      r.power_lit   = !lin;
      r.correlation = held_corr[15:0];
      awaited.push_back(r);
    endfunction

    function void compare(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", field, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(mix_result_t got);
      mix_result_t e;
      if (awaited.size() == 0) begin
        $error("result transfer with no sample awaiting it");
        errors++;
        return;
      end
      e = awaited.pop_front();
      compare("mix_left", e.mix_left, got.mix_left);
      compare("mix_right", e.mix_right, got.mix_right);
      compare("linear_lit", e.linear_lit, got.linear_lit);
      compare("power_lit", e.power_lit, got.power_lit);
      compare("positive_lit", e.positive_lit, got.positive_lit);
      compare("negative_lit", e.negative_lit, got.negative_lit);
      compare("correlation_value", e.correlation, got.correlation);
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_a_left;
  logic signed [15:0] in_b_left;
  logic signed [15:0] in_a_right;
  logic signed [15:0] in_b_right;
  logic signed [15:0] in_cv_sample;
  logic               in_cv_connected;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_mix_left;
  logic signed [15:0] out_mix_right;
  logic               out_linear_lit;
  logic               out_power_lit;
  logic               out_positive_lit;
  logic               out_negative_lit;
  logic signed [15:0] out_correlation_value;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [12:0]        cfg_data;

  mix_scoreboard board;
  bit            stall_free;   // when set, the result side never stalls
  int            stall_left;
  bit            stall_level;

  correlation_adaptive_crossfader i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_a_left             (in_a_left),
    .in_b_left             (in_b_left),
    .in_a_right            (in_a_right),
    .in_b_right            (in_b_right),
    .in_cv_sample          (in_cv_sample),
    .in_cv_connected       (in_cv_connected),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_mix_left          (out_mix_left),
    .out_mix_right         (out_mix_right),
    .out_linear_lit        (out_linear_lit),
    .out_power_lit         (out_power_lit),
    .out_positive_lit      (out_positive_lit),
    .out_negative_lit      (out_negative_lit),
    .out_correlation_value (out_correlation_value),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest legal completion.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // The result side stalls in bursts: mostly short, now and then long,
  // with stretches of no stall at all.
  always @(posedge clk) begin
    if (stall_free) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= stall_level;
    end else begin
      if ($urandom_range(0, 9) < 6) begin
        stall_level <= 1'b0;
        stall_left  <= $urandom_range(0, 30);
        out_stall   <= 1'b0;
      end else begin
        stall_level <= 1'b1;
        stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 200)
                                                   : $urandom_range(0, 5);
        out_stall   <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    mix_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.mix_left     = out_mix_left;
      got.mix_right    = out_mix_right;
      got.linear_lit   = out_linear_lit;
      got.power_lit    = out_power_lit;
      got.positive_lit = out_positive_lit;
      got.negative_lit = out_negative_lit;
      got.correlation  = out_correlation_value;
      board.check_result(got);
    end
  end

  // Offers one sample after a random gap and returns once it is transferred.
  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_sample(sample_t al, sample_t bl, sample_t ar, sample_t br,
                             sample_t cv, logic connected);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(1, 6) : $urandom_range(20, 120);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_a_left       <= al;
    in_b_left       <= bl;
    in_a_right      <= ar;
    in_b_right      <= br;
    in_cv_sample    <= cv;
    in_cv_connected <= connected;
    do @(posedge clk); while (in_stall);
    board.note_sample(al, bl, ar, br, cv, connected);
  endtask

  task automatic send_random();
    send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // Lets every outstanding result arrive so that registers may change.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic configure(logic [1:0] mode, logic [12:0] fader, logic polar);
    drain();
    write_reg(CFG_MODE, mode);
    write_reg(CFG_FADER, fader);
    write_reg(CFG_POLAR, polar);
  endtask

  // A run of left pairs with a chosen relation, so that the correlation
  // climbs past the upper threshold, falls under the lower one, or sits on
  // the degenerate cases where one or both deviations vanish.
  task automatic correlated_run(int shape, int len);
    sample_t a, b, flat_a, flat_b;
    int      span;
    span   = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(100, 8000);
    flat_a = $urandom;
    flat_b = $urandom;
    repeat (len) begin
      a = $urandom_range(0, 2 * span) - span;
      case (shape)
        SHAPE_FOLLOW: begin
          b = a + $signed($urandom_range(0, span / 8)) - span / 16;
        end
        SHAPE_INVERT: begin
          b = (a == -32768) ? 32767 : -a;
        end
        SHAPE_A_FLAT: begin
          a = flat_a;
          b = $urandom;
        end
        SHAPE_BOTH_FLAT: begin
          a = flat_a;
          b = flat_b;
        end
        default: begin
          b = $urandom;
        end
      endcase
      send_sample(a, b, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end
  endtask

  task automatic auto_phase(int items);
    int done;
    int len;
    done = 0;
    while (done < items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 90);
      correlated_run($urandom_range(SHAPE_FOLLOW, SHAPE_BOTH_FLAT), len);
      done += len;
    end
  endtask

  initial begin
    board = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_a_left       = '0;
    in_b_left       = '0;
    in_a_right      = '0;
    in_b_right      = '0;
    in_cv_sample    = '0;
    in_cv_connected = 1'b0;
    out_stall       = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MODE;
    cfg_data        = '0;
    stall_free      = 1'b0;
    stall_left      = 0;
    stall_level     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Linear law at reset settings: full-scale samples, CV at both rails,
    // at zero, and the fader path.
    send_sample(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh7FFF, -16'sh8000, 1'b1);
    send_sample(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 16'sh0000, 1'b1);
    send_sample(16'sh1234, -16'sh4321, 16'sh0001, -16'sh0001, 16'sh3FFF, 1'b1);
    send_sample(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 1'b0);
    repeat (50) send_random();

    // Equal power with a full fader and the CV offset: mixes of equal inputs
    // at mid fade exceed full scale and must saturate.
    stall_free = 1'b1;
    configure(MODE_POWER, 13'd4096, 1'b1);
    send_sample(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh0000, 1'b1);
    send_sample(16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh4000, 1'b1);
    send_sample(16'sh7FFF, -16'sh8000, 16'sh4000, 16'sh4000, 16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, -16'sh8000, 16'sh4000, 16'sh4000, -16'sh8000, 1'b1);
    send_sample(16'sh0100, 16'sh7FFF, -16'sh0100, -16'sh8000, 16'sh0000, 1'b0);
    repeat (50) send_random();
    stall_free = 1'b0;

    // Automatic mode with an oversized fader; the window fills, and slides once it is full.
    configure(MODE_AUTO, 13'd8191, 1'b0);
    send_sample(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0);
    send_sample(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh0000, 1'b0);
    send_sample(16'sh7FFF, 16'sh0000, 16'sh7FFF, -16'sh8000, 16'sh1000, 1'b1);
    send_sample(-16'sh8000, 16'sh0000, -16'sh8000, 16'sh7FFF, 16'sh1000, 1'b1);
    send_sample(16'sh7FFF, -16'sh8000, 16'sh0001, 16'sh0001, 16'sh1000, 1'b1);
    auto_phase(240);

    // Linear law with the correlation held from the automatic phase.
    configure(MODE_LINEAR, 13'd2048, 1'b0);
    repeat (40) send_random();

    // The unused mode code behaves as automatic.
    configure(MODE_AUTO_ALT, 13'($urandom_range(0, 8191)), 1'b1);
    auto_phase(190);

    configure(MODE_POWER, 13'd1, 1'b0);
    repeat (40) send_random();

    configure(MODE_AUTO, 13'($urandom_range(0, 4096)), 1'b1);
    auto_phase(100);

    drain();
    repeat (700) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/caxf_pkg.sv
hdl/correlation_adaptive_crossfader.sv
tb/tb_correlation_adaptive_crossfader.sv
